### design/expgam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expgam_pkg
// shared constants and types for the exposure and gamma tone mapper
// ----------------------------------------------------------------------------
package expgam_pkg;

   // tone table geometry
   localparam int unsigned TABLE_ENTRIES = 65536;
   localparam int unsigned ENTRY_BITS    = 16;
   localparam int unsigned ADDR_BITS     = $clog2(TABLE_ENTRIES);
   localparam int unsigned LAST_ENTRY    = TABLE_ENTRIES - 1;

   // fixed point widths
   localparam int unsigned MANT_BITS   = 24;
   localparam int unsigned SCALE_BITS  = 32;
   localparam int unsigned PROD_BITS   = MANT_BITS + SCALE_BITS;
   localparam int unsigned FRAC_BITS   = 40;
   localparam int unsigned WIDE_BITS   = PROD_BITS + FRAC_BITS;
   localparam int unsigned SHIFT_BITS  = 8;
   localparam int unsigned WEIGHT_BITS = 16;
   localparam int unsigned POS_BITS    = FRAC_BITS + ADDR_BITS;
   localparam int unsigned BLEND_BITS  = ENTRY_BITS + WEIGHT_BITS;
   localparam int unsigned DIFF_BITS   = ENTRY_BITS + 1;
   localparam int unsigned TERM_BITS   = ENTRY_BITS + WEIGHT_BITS + 2;
   localparam int unsigned SCALED_BITS = BLEND_BITS + 9;
   localparam int unsigned QUOT_BITS   = SCALED_BITS - WEIGHT_BITS;
   localparam int unsigned RSUM_BITS   = QUOT_BITS + 1;
   localparam int unsigned BYTE_BITS   = 8;

   localparam logic [ENTRY_BITS-1:0]  ENTRY_MAX  = '1;
   localparam logic [SCALED_BITS-1:0] ROUND_TERM = SCALED_BITS'(ENTRY_MAX) << (WEIGHT_BITS - 1);

   // float decode
   localparam logic [7:0] EXPO_ALL_ONES   = 8'hFF;
   localparam logic [7:0] SHIFT_BIAS      = 8'd166;
   localparam logic [7:0] SUBNORMAL_SHIFT = 8'd165;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 32'h0001_0000;
   localparam logic [BYTE_BITS-1:0]  BYTE_MAX    = 8'd255;

   // word modes
   localparam logic MODE_WRITE   = 1'b0;
   localparam logic MODE_CONVERT = 1'b1;

   typedef enum logic [1:0] {
      CLS_CALC = 2'd0,
      CLS_ZERO = 2'd1,
      CLS_FULL = 2'd2
   } tone_class_type;

endpackage

### design/exposure_gamma_lut_to_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exposure_gamma_lut_to_byte
// hdr float samples to display bytes via exposure scale and tone table blend
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  mode, table_address, table_value,
//                                             sample_bits
//  rsp      out        rsp_valid / rsp_ready  tone_byte (convert words only)
//  csr      in         csr_valid / csr_ready  exposure_gain
//
//  one word per clock while rsp is not stalled; rsp_valid of a convert word rises once it reaches the stage 7 register
//  table writes happen at the memory read stage, so reads and writes keep
//  word order with no forwarding; the table has one write and two read ports
//  synchronous reset clears valids and the loaded flag and sets scale to SCALE_RESET; the table is
//  not cleared and takes words right out of reset
//  a stalled rsp holds only the stages behind it; bubbles close up
// ----------------------------------------------------------------------------
module exposure_gamma_lut_to_byte (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_table_address,
   input  logic [15:0] req_table_value,
   input  logic [31:0] req_sample_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tone_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_exposure_gain
);

   logic [expgam_pkg::SCALE_BITS-1:0] scale_ff;
   logic                              loaded_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic en1, en2, en3, en4, en5, en6, en7;

   // stage 1
   logic                              sign_w;
   logic [7:0]                        expo_w;
   logic [22:0]                       mant_w;
   logic [expgam_pkg::MANT_BITS-1:0]  mant_full;
   logic                              mode1_ff;
   logic [15:0]                       addr1_ff, val1_ff;
   expgam_pkg::tone_class_type        cls1_in, cls1_ff;
   logic                              le0_1_in, le0_1_ff;
   logic [expgam_pkg::SHIFT_BITS-1:0] shift1_in, shift1_ff;
   logic [expgam_pkg::PROD_BITS-1:0]  prod1_in, prod1_ff;

   // stage 2
   logic [expgam_pkg::WIDE_BITS-1:0]  wide2;
   logic                              mode2_ff;
   logic [15:0]                       addr2_ff, val2_ff;
   expgam_pkg::tone_class_type        cls2_in, cls2_ff;
   logic [expgam_pkg::FRAC_BITS-1:0]  frac2_ff;

   // stage 3
   logic [expgam_pkg::POS_BITS-1:0]    pos3;
   logic                               mode3_ff;
   logic [15:0]                        addr3_ff, val3_ff;
   expgam_pkg::tone_class_type         cls3_ff;
   logic [expgam_pkg::ADDR_BITS-1:0]   idx0_in, idx0_ff, idx1_in, idx1_ff;
   logic [expgam_pkg::WEIGHT_BITS-1:0] weight3_in, weight3_ff;
   logic                               table_wr;

   // stage 4
   logic [expgam_pkg::ENTRY_BITS-1:0]  table_mem [expgam_pkg::TABLE_ENTRIES];
   logic [expgam_pkg::ENTRY_BITS-1:0]  a4_ff, b4_ff;
   logic [expgam_pkg::WEIGHT_BITS-1:0] weight4_ff;
   expgam_pkg::tone_class_type         cls4_in, cls4_ff;

   // stage 5
   logic signed [expgam_pkg::DIFF_BITS-1:0] diff5;
   logic signed [expgam_pkg::TERM_BITS-1:0] term5, sum5;
   logic [expgam_pkg::BLEND_BITS-1:0]       blend5_ff;
   expgam_pkg::tone_class_type              cls5_ff;

   // stage 6
   logic [expgam_pkg::SCALED_BITS-1:0] scaled6;
   logic [expgam_pkg::QUOT_BITS-1:0]   quot6_ff;
   expgam_pkg::tone_class_type         cls6_ff;

   // stage 7
   logic [expgam_pkg::RSUM_BITS-1:0]  rsum7;
   logic [9:0]                        rq7;
   logic [expgam_pkg::BYTE_BITS-1:0]  calc7;
   logic [expgam_pkg::BYTE_BITS-1:0]  byte7_in, byte7_ff;

   // ---------------------------------------------------------------- control
   assign en7 = !v7_ff || rsp_ready;
   assign en6 = !v6_ff || en7;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_ready = en1;
   assign csr_ready = 1'b1;
   assign rsp_valid = v7_ff;
   assign rsp_tone_byte = byte7_ff;

   assign table_wr = en4 && v3_ff && (mode3_ff == expgam_pkg::MODE_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         v6_ff     <= 1'b0;
         v7_ff     <= 1'b0;
         loaded_ff <= 1'b0;
         scale_ff  <= expgam_pkg::SCALE_RESET;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff && (mode3_ff == expgam_pkg::MODE_CONVERT);
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
         if (en7) v7_ff <= v6_ff;
         if (table_wr) loaded_ff <= 1'b1;
         if (csr_valid) scale_ff <= csr_exposure_gain;
      end
   end

   // ---------------------------------------------------- stage 1: decode, mul
   assign sign_w = req_sample_bits[31];
   assign expo_w = req_sample_bits[30:23];
   assign mant_w = req_sample_bits[22:0];

   always_comb begin
      cls1_in = expgam_pkg::CLS_CALC;
      if (expo_w == expgam_pkg::EXPO_ALL_ONES) begin
         cls1_in = (mant_w != '0 || sign_w) ? expgam_pkg::CLS_ZERO : expgam_pkg::CLS_FULL;
      end else if (sign_w || (expo_w == '0 && mant_w == '0)) begin
         cls1_in = expgam_pkg::CLS_ZERO;
      end
      mant_full = (expo_w == '0) ? {1'b0, mant_w} : {1'b1, mant_w};
      le0_1_in  = expo_w >= expgam_pkg::SHIFT_BIAS;
      shift1_in = (expo_w == '0) ? expgam_pkg::SUBNORMAL_SHIFT
                                 : expgam_pkg::SHIFT_BIAS - expo_w;
      prod1_in  = expgam_pkg::PROD_BITS'(mant_full) * expgam_pkg::PROD_BITS'(scale_ff);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         mode1_ff  <= req_mode;
         addr1_ff  <= req_table_address;
         val1_ff   <= req_table_value;
         cls1_ff   <= cls1_in;
         le0_1_ff  <= le0_1_in;
         shift1_ff <= shift1_in;
         prod1_ff  <= prod1_in;
      end
   end

   // ----------------------------------------- stage 2: align to a fraction
   assign wide2 = {prod1_ff, expgam_pkg::FRAC_BITS'(0)} >> shift1_ff;

   always_comb begin
      cls2_in = cls1_ff;
      if (cls1_ff == expgam_pkg::CLS_CALC) begin
         if (prod1_ff == '0) begin
            cls2_in = expgam_pkg::CLS_ZERO;
         end else if (le0_1_ff || wide2[expgam_pkg::WIDE_BITS-1:expgam_pkg::FRAC_BITS] != '0) begin
            cls2_in = expgam_pkg::CLS_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         mode2_ff <= mode1_ff;
         addr2_ff <= addr1_ff;
         val2_ff  <= val1_ff;
         cls2_ff  <= cls2_in;
         frac2_ff <= wide2[expgam_pkg::FRAC_BITS-1:0];
      end
   end

   // ------------------------------------------- stage 3: table position
   always_comb begin
      pos3 = expgam_pkg::POS_BITS'(frac2_ff)
           * expgam_pkg::POS_BITS'(expgam_pkg::LAST_ENTRY);
      idx0_in = pos3[expgam_pkg::POS_BITS-1:expgam_pkg::FRAC_BITS];
      idx1_in = (idx0_in == expgam_pkg::ADDR_BITS'(expgam_pkg::LAST_ENTRY))
              ? idx0_in : idx0_in + expgam_pkg::ADDR_BITS'(1);
      weight3_in = pos3[expgam_pkg::FRAC_BITS-1 -: expgam_pkg::WEIGHT_BITS];
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         mode3_ff   <= mode2_ff;
         addr3_ff   <= addr2_ff;
         val3_ff    <= val2_ff;
         cls3_ff    <= cls2_ff;
         idx0_ff    <= idx0_in;
         idx1_ff    <= idx1_in;
         weight3_ff <= weight3_in;
      end
   end

   // --------------------------------------- stage 4: table read and write
   assign cls4_in = loaded_ff ? cls3_ff : expgam_pkg::CLS_ZERO;

   always_ff @(posedge clock) begin
      if (en4) begin
         if (table_wr && (32'(addr3_ff) < expgam_pkg::TABLE_ENTRIES)) begin
            table_mem[addr3_ff[expgam_pkg::ADDR_BITS-1:0]]
               <= expgam_pkg::ENTRY_BITS'(val3_ff);
         end
         a4_ff      <= table_mem[idx0_ff];
         b4_ff      <= table_mem[idx1_ff];
         weight4_ff <= weight3_ff;
         cls4_ff    <= cls4_in;
      end
   end

   // ----------------------------------------------------- stage 5: blend
   always_comb begin
      diff5 = $signed({1'b0, b4_ff}) - $signed({1'b0, a4_ff});
      term5 = diff5 * $signed({1'b0, weight4_ff});
      sum5  = $signed({2'b00, a4_ff, expgam_pkg::WEIGHT_BITS'(0)}) + term5;
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         blend5_ff <= sum5[expgam_pkg::BLEND_BITS-1:0];
         cls5_ff   <= cls4_ff;
      end
   end

   // ------------------------------------------- stage 6: scale to 255
   assign scaled6 = expgam_pkg::SCALED_BITS'({blend5_ff, 8'b0})
                  - expgam_pkg::SCALED_BITS'(blend5_ff)
                  + expgam_pkg::ROUND_TERM;

   always_ff @(posedge clock) begin
      if (en6) begin
         quot6_ff <= scaled6[expgam_pkg::SCALED_BITS-1:expgam_pkg::WEIGHT_BITS];
         cls6_ff  <= cls5_ff;
      end
   end

   // --------------------------- stage 7: divide by entry max, output word
   always_comb begin
      rsum7 = expgam_pkg::RSUM_BITS'(quot6_ff)
            + expgam_pkg::RSUM_BITS'(quot6_ff >> expgam_pkg::ENTRY_BITS)
            + expgam_pkg::RSUM_BITS'(1);
      rq7   = rsum7[expgam_pkg::RSUM_BITS-1:expgam_pkg::ENTRY_BITS];
      calc7 = (rq7 > 10'(expgam_pkg::BYTE_MAX)) ? expgam_pkg::BYTE_MAX : rq7[7:0];
      priority if (cls6_ff == expgam_pkg::CLS_ZERO) begin
         byte7_in = '0;
      end else if (cls6_ff == expgam_pkg::CLS_FULL) begin
         byte7_in = expgam_pkg::BYTE_MAX;
      end else begin
         byte7_in = calc7;
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         byte7_ff <= byte7_in;
      end
   end

endmodule
